/* rtl/u8sd_pkg.sv */
// Shared types and codes for the legacy UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CHAR    = 2'd0,
    ST_INVALID = 2'd1,
    ST_SHORT   = 2'd2,
    ST_ENDED   = 2'd3
  } status_t;

  // Decoder state carried from beat to beat
  typedef struct packed {
    logic [30:0] partial_value;
    logic [2:0]  bytes_pending;
    logic        stopped;
  } dec_state_t;

  // One step's result, with a flag that says whether a beat goes out
  typedef struct packed {
    logic        emit;
    logic [30:0] code_point;
    status_t     status;
    logic        buffer_end;
  } dec_result_t;

endpackage

`default_nettype wire

/* rtl/u8sd_in_reg.sv */
// Input register stage: holds one byte beat until the decode step takes it.
`default_nettype none

module u8sd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       buffer_last,
  output logic       held_valid,
  input  logic       held_take,
  output logic [7:0] held_byte,
  output logic       held_last
);

  // Free slot, or the held beat leaves this cycle
  assign in_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= byte_in;
      held_last <= buffer_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/u8sd_step.sv */
// Decode step: next state and optional result for one byte.
`default_nettype none

module u8sd_step (
  input  logic                 [7:0] byte_in,
  input  logic                       buffer_last,
  input  u8sd_pkg::dec_state_t       cur,
  output u8sd_pkg::dec_state_t       nxt,
  output u8sd_pkg::dec_result_t      res
);

  logic [2:0]  lead_len;
  logic [4:0]  lead_val;
  logic [30:0] shifted;
  logic [2:0]  pend_dec;
  u8sd_pkg::dec_state_t upd;

  // Lead byte classification; length 0 marks an invalid lead
  always_comb begin
    lead_len = 3'd0;
    lead_val = 5'd0;
    unique case (byte_in) inside
      [8'h00:8'h7F]: lead_len = 3'd1;
      [8'h80:8'hC1]: lead_len = 3'd0;
      [8'hC2:8'hDF]: begin
        lead_len = 3'd2;
        lead_val = byte_in[4:0];
      end
      [8'hE0:8'hEF]: begin
        lead_len = 3'd3;
        lead_val = {1'b0, byte_in[3:0]};
      end
      [8'hF0:8'hF7]: begin
        lead_len = 3'd4;
        lead_val = {2'b0, byte_in[2:0]};
      end
      [8'hF8:8'hFB]: begin
        lead_len = 3'd5;
        lead_val = {3'b0, byte_in[1:0]};
      end
      [8'hFC:8'hFD]: begin
        lead_len = 3'd6;
        lead_val = {4'b0, byte_in[0]};
      end
      default: lead_len = 3'd0;
    endcase
  end

  assign shifted  = {cur.partial_value[24:0], byte_in[5:0]};
  assign pend_dec = cur.bytes_pending - 3'd1;

  always_comb begin
    upd            = cur;
    res.emit       = 1'b0;
    res.code_point = '0;
    res.status     = u8sd_pkg::ST_CHAR;
    res.buffer_end = buffer_last;

    if (cur.stopped) begin
      // Silent until the buffer ends
      if (buffer_last) begin
        res.emit   = 1'b1;
        res.status = u8sd_pkg::ST_ENDED;
      end
    end else if (cur.bytes_pending == 3'd0) begin
      if (lead_len == 3'd1) begin
        res.emit       = 1'b1;
        res.code_point = {23'b0, byte_in};
      end else if (lead_len == 3'd0) begin
        res.emit    = 1'b1;
        res.status  = u8sd_pkg::ST_INVALID;
        upd.stopped = 1'b1;
      end else begin
        upd.partial_value = {26'b0, lead_val};
        upd.bytes_pending = lead_len - 3'd1;
        if (buffer_last) begin
          res.emit   = 1'b1;
          res.status = u8sd_pkg::ST_SHORT;
        end
      end
    end else if (byte_in[7:6] != 2'b10) begin
      // Broken continuation; a zero byte means the text was cut
      res.emit    = 1'b1;
      res.status  = (byte_in == 8'h00) ? u8sd_pkg::ST_SHORT : u8sd_pkg::ST_INVALID;
      upd.stopped = 1'b1;
    end else if (pend_dec == 3'd0) begin
      res.emit          = 1'b1;
      res.code_point    = shifted;
      upd.partial_value = '0;
      upd.bytes_pending = 3'd0;
    end else begin
      upd.partial_value = shifted;
      upd.bytes_pending = pend_dec;
      if (buffer_last) begin
        res.emit   = 1'b1;
        res.status = u8sd_pkg::ST_SHORT;
      end
    end
  end

  // Every buffer end clears the state
  assign nxt = buffer_last ? '0 : upd;

endmodule

`default_nettype wire

/* rtl/utf8_stream_decoder.sv */
// Top level of the legacy UTF-8 stream decoder (up to six-byte sequences).
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-------------------
//   in      | in_valid, in_ready, byte_in, buffer_last  | one byte per beat
//   out     | out_valid, out_ready, code_point, status, | zero or one result
//           | buffer_end                                | beat per byte
//
// One byte per cycle sustained while the output is not stalled: input register, one decode step, result
// register. A result is registered after its byte leaves the input register; an output stall can hold it there.
// Reset clears both valid flags and the decoder state.
// A stalled result holds its register; bytes that give no result still
// pass through and update the state while the output is stalled.
`default_nettype none

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        buffer_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic [1:0]  status,
  output logic        buffer_end
);

  logic       held_valid;
  logic       held_take;
  logic [7:0] held_byte;
  logic       held_last;
  logic       out_free;

  u8sd_pkg::dec_state_t  state;
  u8sd_pkg::dec_state_t  state_next;
  u8sd_pkg::dec_result_t step_res;

  u8sd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (byte_in),
    .buffer_last (buffer_last),
    .held_valid  (held_valid),
    .held_take   (held_take),
    .held_byte   (held_byte),
    .held_last   (held_last)
  );

  u8sd_step u_step (
    .byte_in     (held_byte),
    .buffer_last (held_last),
    .cur         (state),
    .nxt         (state_next),
    .res         (step_res)
  );

  // Step fires when its result, if any, has a place to go
  assign out_free  = !out_valid || out_ready;
  assign held_take = held_valid && (!step_res.emit || out_free);

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (held_take) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= held_take && step_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (held_take && step_res.emit) begin
      code_point <= step_res.code_point;
      status     <= step_res.status;
      buffer_end <= step_res.buffer_end;
    end
  end

endmodule

`default_nettype wire
